// ===== sv/dsg_pkg.sv =====
package dsg_pkg;

	// field widths
	localparam int CENTER_W = 14;
	localparam int COORD_W  = 15;
	localparam int RADIUS_W = 5;
	localparam int OFFS_W   = 6;
	localparam int AREA_W   = 10;
	localparam int DIM_W    = 13;
	localparam int ROW_W    = 12;

	localparam logic [DIM_W-1:0] DIM_LIMIT = 13'd4096;
	localparam logic [DIM_W-1:0] DIM_RESET = 13'd1024;

	// configuration register indexes
	localparam logic CFG_MASK_WIDTH  = 1'b0;
	localparam logic CFG_MASK_HEIGHT = 1'b1;

	// one unclipped row span handed from front to back
	typedef struct packed {
		logic signed [COORD_W-1:0] row;
		logic signed [COORD_W-1:0] lo;
		logic signed [COORD_W-1:0] hi;
		logic                      last;
	} span_cmd_t;

	// smallest s with s*s >= n, digit-by-digit over five result bits
	function automatic logic [OFFS_W-1:0] ceil_sqrt(input logic [AREA_W-1:0] n);
		logic [AREA_W:0] op;
		logic [AREA_W:0] res;
		logic [AREA_W:0] one;
		op  = {1'b0, n};
		res = '0;
		one = 11'd256;
		for (int i = 0; i < 5; i++) begin
			if (op >= res + one) begin
				op  = op - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		return res[OFFS_W-1:0] + {5'd0, (op != '0)};
	endfunction

endpackage

// ===== sv/disc_span_generator.sv =====
// Filled-disc scanline generator.
// s_* channel: one beat per disc request, s_tdata = {center_y, center_x} plus radius
//   (center_x [13:0], center_y [27:14], disc_radius [32:28]); radius saturates at
//   MAX_RADIUS. A radius r disc yields 2r+1 beats on m_*, top row first.
// m_* channel: one beat per row; m_tdata holds span_row, span_start, span_end
//   (end exclusive, clipped to the mask), m_tuser flags an empty row (off-image or
//   clipped away, payload zero), m_tlast marks the final row of the disc.
// cfg_* channel: index 0 sets mask_width, index 1 mask_height; values above 4096
//   are stored as 4096. Write only while no disc is in flight.
// Timing: the front sequencer walks one row per cycle while the queue is not full;
//   a disc holds the input until its 2r+1 rows are walked, and the next request is
//   taken once the last row enters the queue.
// A small command queue sits between the row sequencer and the clip/output stage,
//   so a stalled m_tready fills the queue and only then halts the sequencer; no beat
//   is lost or repeated.
// Reset: idle, queue empty, both mask dimensions 1024.
module disc_span_generator #(
	parameter int MAX_RADIUS  = 31,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // center_x, center_y, disc_radius, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // span_row, span_start, span_end, zero pad
	output logic        m_tuser,   // span_empty
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	logic [dsg_pkg::DIM_W-1:0] mask_width_q;
	logic [dsg_pkg::DIM_W-1:0] mask_height_q;
	logic [dsg_pkg::DIM_W-1:0] cfg_sat;

	dsg_pkg::span_cmd_t        push_cmd;
	dsg_pkg::span_cmd_t        head_cmd;
	logic                      push_valid;
	logic                      push;
	logic                      q_full;
	logic                      q_not_empty;
	logic                      pop;

	logic [dsg_pkg::ROW_W-1:0] span_row;
	logic [dsg_pkg::DIM_W-1:0] span_start;
	logic [dsg_pkg::DIM_W-1:0] span_end;

	// configuration registers
	assign cfg_ready = 1'b1;
	assign cfg_sat   = (cfg_data > dsg_pkg::DIM_LIMIT) ? dsg_pkg::DIM_LIMIT : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_width_q  <= dsg_pkg::DIM_RESET;
			mask_height_q <= dsg_pkg::DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dsg_pkg::CFG_MASK_WIDTH:  mask_width_q  <= cfg_sat;
				dsg_pkg::CFG_MASK_HEIGHT: mask_height_q <= cfg_sat;
				default: ;
			endcase
		end
	end

	// row sequencer
	dsg_front #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (s_tvalid),
		.req_ready  (s_tready),
		.req_cx     ($signed(s_tdata[13:0])),
		.req_cy     ($signed(s_tdata[27:14])),
		.req_radius (s_tdata[32:28]),
		.cmd_valid  (push_valid),
		.cmd_full   (q_full),
		.cmd        (push_cmd)
	);

	assign push = push_valid && !q_full;

	// command queue
	dsg_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (push),
		.wr_data   (push_cmd),
		.full      (q_full),
		.rd_en     (pop),
		.rd_data   (head_cmd),
		.not_empty (q_not_empty)
	);

	// clip and output stage
	dsg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.mask_width  (mask_width_q),
		.mask_height (mask_height_q),
		.cmd_valid   (q_not_empty),
		.cmd_pop     (pop),
		.cmd         (head_cmd),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.span_row    (span_row),
		.span_start  (span_start),
		.span_end    (span_end),
		.span_empty  (m_tuser),
		.last_span   (m_tlast)
	);

	assign m_tdata = {2'b00, span_end, span_start, span_row};

endmodule

// ===== sv/dsg_front.sv =====
module dsg_front #(
	parameter int MAX_RADIUS = 31
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  logic signed [dsg_pkg::CENTER_W-1:0]  req_cx,
	input  logic signed [dsg_pkg::CENTER_W-1:0]  req_cy,
	input  logic        [dsg_pkg::RADIUS_W-1:0]  req_radius,
	output logic                                 cmd_valid,
	input  logic                                 cmd_full,
	output dsg_pkg::span_cmd_t                   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} front_state_t;

	localparam logic [dsg_pkg::RADIUS_W-1:0] RMAX = dsg_pkg::RADIUS_W'(MAX_RADIUS);

	front_state_t                        state_q;
	logic signed [dsg_pkg::OFFS_W-1:0]   d_q;
	logic        [dsg_pkg::AREA_W-1:0]   n_q;
	logic signed [dsg_pkg::CENTER_W-1:0] cx_q;
	logic signed [dsg_pkg::CENTER_W-1:0] cy_q;
	logic        [dsg_pkg::RADIUS_W-1:0] r_q;

	logic                                accept;
	logic                                push;
	logic                                at_last;
	logic        [dsg_pkg::RADIUS_W-1:0] r_sat;
	logic        [dsg_pkg::OFFS_W-1:0]   s;
	logic        [dsg_pkg::AREA_W+1:0]   step;
	logic        [dsg_pkg::AREA_W+1:0]   n_next;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign cmd_valid = (state_q == ST_RUN);
	assign push      = cmd_valid && !cmd_full;
	assign at_last   = (d_q == $signed({1'b0, r_q}));
	assign r_sat     = (req_radius > RMAX) ? RMAX : req_radius;

	// n = r*r - d*d stepped down by 2d+1 per row
	assign step   = {{5{d_q[dsg_pkg::OFFS_W-1]}}, d_q, 1'b1};
	assign n_next = {2'b00, n_q} - step;

	// row span before clipping
	assign s        = dsg_pkg::ceil_sqrt(n_q);
	assign cmd.row  = $signed({cy_q[dsg_pkg::CENTER_W-1], cy_q})
	                + $signed({{9{d_q[dsg_pkg::OFFS_W-1]}}, d_q});
	assign cmd.lo   = $signed({cx_q[dsg_pkg::CENTER_W-1], cx_q}) - $signed({9'd0, s});
	assign cmd.hi   = $signed({cx_q[dsg_pkg::CENTER_W-1], cx_q}) + $signed({9'd0, s});
	assign cmd.last = at_last;

	// row sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			d_q     <= '0;
			n_q     <= '0;
			r_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						r_q     <= r_sat;
						d_q     <= $signed(~{1'b0, r_sat} + 6'd1);
						n_q     <= '0;
					end
				end
				ST_RUN: begin
					if (push) begin
						if (at_last) begin
							state_q <= ST_IDLE;
						end else begin
							d_q <= d_q + 6'sd1;
							n_q <= n_next[dsg_pkg::AREA_W-1:0];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// held centre
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q <= req_cx;
			cy_q <= req_cy;
		end
	end

endmodule

// ===== sv/dsg_fifo.sv =====
module dsg_fifo #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  dsg_pkg::span_cmd_t wr_data,
	output logic               full,
	input  logic               rd_en,
	output dsg_pkg::span_cmd_t rd_data,
	output logic               not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	dsg_pkg::span_cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== sv/dsg_back.sv =====
module dsg_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [dsg_pkg::DIM_W-1:0]        mask_width,
	input  logic [dsg_pkg::DIM_W-1:0]        mask_height,
	input  logic                             cmd_valid,
	output logic                             cmd_pop,
	input  dsg_pkg::span_cmd_t               cmd,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [dsg_pkg::ROW_W-1:0]        span_row,
	output logic [dsg_pkg::DIM_W-1:0]        span_start,
	output logic [dsg_pkg::DIM_W-1:0]        span_end,
	output logic                             span_empty,
	output logic                             last_span
);

	logic                             load;
	logic signed [dsg_pkg::COORD_W-1:0] w_s;
	logic signed [dsg_pkg::COORD_W-1:0] h_s;
	logic signed [dsg_pkg::COORD_W-1:0] lo_c;
	logic signed [dsg_pkg::COORD_W-1:0] hi_c;
	logic                             empty;

	assign load    = !out_valid || out_ready;
	assign cmd_pop = cmd_valid && load;

	// clip against the mask
	assign w_s   = $signed({2'b00, mask_width});
	assign h_s   = $signed({2'b00, mask_height});
	assign lo_c  = (cmd.lo < 0) ? '0 : cmd.lo;
	assign hi_c  = (cmd.hi > w_s) ? w_s : cmd.hi;
	assign empty = (cmd.row < 0) || (cmd.row >= h_s) || (lo_c >= hi_c);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			span_empty <= empty;
			last_span  <= cmd.last;
			span_row   <= empty ? '0 : cmd.row[dsg_pkg::ROW_W-1:0];
			span_start <= empty ? '0 : lo_c[dsg_pkg::DIM_W-1:0];
			span_end   <= empty ? '0 : hi_c[dsg_pkg::DIM_W-1:0];
		end
	end

endmodule

// ===== sv/dsg_checker.sv =====
module dsg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// a stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("output beat changed while stalled");

	// empty rows carry a zero payload
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 40'd0)
		else $error("empty span with nonzero payload");

	// a real span is nonempty and inside the mask limit
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[24:12] < m_tdata[37:25])
		&& (m_tdata[37:25] <= 13'd4096))
		else $error("span bounds out of order");

	// one disc at a time: request side closes after a beat
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while a disc is in progress");

endmodule

bind disc_span_generator dsg_checker u_dsg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== bench/disc_span_generator_test.sv =====
`timescale 1ns / 100ps

module disc_span_generator_test;

	localparam int MAX_RAD     = 31;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 8;

	// one span beat as it appears on the master side
	typedef struct packed {
		logic [dsg_pkg::ROW_W-1:0] row;
		logic [dsg_pkg::DIM_W-1:0] first_col;
		logic [dsg_pkg::DIM_W-1:0] stop_col;
		logic                      empty;
		logic                      last;
	} span_beat_t;

	// directed disc requests; typed rows carry a fixed single-span expectation
	typedef struct packed {
		logic signed [dsg_pkg::CENTER_W-1:0] cx;
		logic signed [dsg_pkg::CENTER_W-1:0] cy;
		logic [dsg_pkg::RADIUS_W-1:0]        rad;
		logic                                typed;
	} disc_row_t;

	// mask settings per phase; rand_dims picks fresh dimensions at run time
	typedef struct packed {
		logic [dsg_pkg::DIM_W-1:0] w;
		logic [dsg_pkg::DIM_W-1:0] h;
		logic [7:0]                n_discs;
		logic                      hold;
		logic                      rand_dims;
	} mask_phase_t;

	localparam int N_DIRECTED = 24;
	localparam int N_PHASES   = 8;

	disc_row_t directed_discs [N_DIRECTED] = '{
		'{14'sd100,   14'sd100,   5'd0,  1'b1},
		'{14'sd0,     14'sd0,     5'd0,  1'b1},
		'{14'sd8191,  14'sd8191,  5'd0,  1'b1},
		'{-14'sd4096, -14'sd4096, 5'd0,  1'b1},
		'{14'sd512,   14'sd512,   5'd1,  1'b0},
		'{14'sd512,   14'sd512,   5'd2,  1'b0},
		'{14'sd512,   14'sd512,   5'd31, 1'b0},
		'{14'sd0,     14'sd0,     5'd31, 1'b0},
		'{14'sd1023,  14'sd1023,  5'd31, 1'b0},
		'{-14'sd4096, -14'sd4096, 5'd31, 1'b0},
		'{14'sd8191,  14'sd8191,  5'd31, 1'b0},
		'{-14'sd4096, 14'sd8191,  5'd17, 1'b0},
		'{14'sd8191,  -14'sd4096, 5'd9,  1'b0},
		'{-14'sd1,    14'sd500,   5'd5,  1'b0},
		'{14'sd1024,  14'sd500,   5'd3,  1'b0},
		'{14'sd1027,  14'sd600,   5'd3,  1'b0},
		'{14'sd500,   -14'sd5,    5'd5,  1'b0},
		'{14'sd500,   14'sd1020,  5'd10, 1'b0},
		'{-14'sd31,   14'sd200,   5'd31, 1'b0},
		'{-14'sd30,   14'sd200,   5'd31, 1'b0},
		'{14'sd1054,  14'sd300,   5'd31, 1'b0},
		'{14'sd3000,  14'sd3000,  5'd7,  1'b0},
		'{14'sd5461,  -14'sd2731, 5'd21, 1'b0},
		'{-14'sd2731, 14'sd5461,  5'd10, 1'b0}
	};

	mask_phase_t mask_phases [N_PHASES] = '{
		'{13'd4096, 13'd4096, 8'd30, 1'b0, 1'b0},
		'{13'd1,    13'd1,    8'd25, 1'b0, 1'b0},
		'{13'd0,    13'd0,    8'd15, 1'b0, 1'b0},
		'{13'd8191, 13'd6000, 8'd25, 1'b0, 1'b0},
		'{13'd64,   13'd48,   8'd40, 1'b1, 1'b0},
		'{13'd0,    13'd0,    8'd40, 1'b0, 1'b1},
		'{13'd0,    13'd0,    8'd40, 1'b0, 1'b1},
		'{13'd1024, 13'd1024, 8'd60, 1'b0, 1'b0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;    // center_x, center_y, disc_radius, zero pad
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;    // span_row, span_start, span_end, zero pad
	logic        m_tuser;    // span_empty
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [12:0] cfg_data;

	// predictor state: mask registers as written, spans still owed
	logic [dsg_pkg::DIM_W-1:0] mask_w;
	logic [dsg_pkg::DIM_W-1:0] mask_h;
	span_beat_t                spans_due [$];
	int                        mismatches;

	// sender burst state and receiver hold request
	int burst_left;
	bit no_gaps;
	bit hold_req;

	disc_span_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop if the run hangs
	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// smallest s with s*s >= n
	function automatic int ceil_root(input int n);
		int s;
		s = 0;
		while (s * s < n)
			s++;
		return s;
	endfunction

	function automatic int clip_dim(input logic [dsg_pkg::DIM_W-1:0] v);
		return (v > dsg_pkg::DIM_LIMIT) ? int'(dsg_pkg::DIM_LIMIT) : int'(v);
	endfunction

	// queue the 2r+1 spans of one disc, top row first
	function automatic void predict_spans(input logic signed [dsg_pkg::CENTER_W-1:0] cx_f,
			input logic signed [dsg_pkg::CENTER_W-1:0] cy_f,
			input logic [dsg_pkg::RADIUS_W-1:0] rad_f);
		int cx, cy, r, w, h, d, row, s, lo, hi;
		span_beat_t sp;
		cx = cx_f;
		cy = cy_f;
		r  = rad_f;
		if (r > MAX_RAD)
			r = MAX_RAD;
		w = clip_dim(mask_w);
		h = clip_dim(mask_h);
		for (d = -r; d <= r; d++) begin
			row = cy + d;
			s   = ceil_root(r * r - d * d);
			lo  = (cx - s < 0) ? 0 : cx - s;
			hi  = (cx + s > w) ? w : cx + s;
			sp  = '0;
			if (row < 0 || row >= h || lo >= hi) begin
				sp.empty = 1'b1;
			end else begin
				sp.row       = row[dsg_pkg::ROW_W-1:0];
				sp.first_col = lo[dsg_pkg::DIM_W-1:0];
				sp.stop_col  = hi[dsg_pkg::DIM_W-1:0];
			end
			sp.last = (d == r);
			spans_due.push_back(sp);
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] span mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// register write; only called with nothing in flight
	task automatic write_mask_reg(input logic idx, input logic [12:0] value);
		cfg_index = idx;
		cfg_data  = value;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == dsg_pkg::CFG_MASK_WIDTH)
			mask_w = value;
		else
			mask_h = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// offer one disc request; called at a falling edge, returns at one
	task automatic send_disc(input int cx, input int cy, input int rad, input bit typed);
		int gap;
		span_beat_t fixed_span;
		logic signed [dsg_pkg::CENTER_W-1:0] cx_f;
		logic signed [dsg_pkg::CENTER_W-1:0] cy_f;
		logic [dsg_pkg::RADIUS_W-1:0] rad_f;
		cx_f = cx[dsg_pkg::CENTER_W-1:0];
		cy_f = cy[dsg_pkg::CENTER_W-1:0];
		rad_f = rad[dsg_pkg::RADIUS_W-1:0];
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			if (no_gaps)
				gap = 0;
			else if ($urandom_range(0, 7) == 0)
				gap = $urandom_range(10, 40);
			else
				gap = $urandom_range(0, 3);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tdata  = {7'd0, rad_f, cy_f, cx_f};
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (typed) begin
			fixed_span       = '0;
			fixed_span.empty = 1'b1;
			fixed_span.last  = 1'b1;
			spans_due.push_back(fixed_span);
		end else begin
			predict_spans(cx_f, cy_f, rad_f);
		end
		@(negedge clk);
	endtask

	// mostly discs touching the mask, some at the edges, some anywhere
	task automatic send_random_disc();
		int w, h, kind, cx, cy, rad;
		w = clip_dim(mask_w);
		h = clip_dim(mask_h);
		kind = $urandom_range(0, 9);
		rad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 8);
		if (kind <= 6) begin
			cx = $urandom_range(0, w + 80) - 40;
			cy = $urandom_range(0, h + 80) - 40;
		end else if (kind == 7) begin
			rad = $urandom_range(24, 31);
			cx = $urandom_range(0, 1) ? $urandom_range(0, 62) - 31
			                          : w + $urandom_range(0, 62) - 31;
			cy = $urandom_range(0, 1) ? $urandom_range(0, 62) - 31
			                          : h + $urandom_range(0, 62) - 31;
		end else begin
			cx = $urandom_range(0, 12287) - 4096;
			cy = $urandom_range(0, 12287) - 4096;
		end
		send_disc(cx, cy, rad, 1'b0);
	endtask

	// stop offering, wait for every owed span, then let the pipe settle
	task automatic wait_drained();
		s_tvalid   = 1'b0;
		burst_left = 0;
		while (spans_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// receiver: stall patterns in windows, long hold when asked
	initial begin : span_sink
		int mode, n;
		bit toggle;
		m_tready = 1'b0;
		toggle   = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				mode = $urandom_range(0, 3);
				n    = $urandom_range(8, 80);
				repeat (n) begin
					case (mode)
						0: m_tready = 1'b1;
						1: m_tready = 1'($urandom_range(0, 1));
						2: m_tready = ($urandom_range(0, 3) == 0);
						default: begin
							toggle   = ~toggle;
							m_tready = toggle;
						end
					endcase
					@(negedge clk);
				end
			end
		end
	end

	// compare each accepted span beat with the oldest owed span
	always @(posedge clk) begin : span_check
		span_beat_t got;
		span_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.row       = m_tdata[11:0];
			got.first_col = m_tdata[24:12];
			got.stop_col  = m_tdata[37:25];
			got.empty     = m_tuser;
			got.last      = m_tlast;
			if (spans_due.size() == 0) begin
				report_mismatch($sformatf(
					"unexpected beat row=%0d cols=[%0d,%0d) empty=%b last=%b",
					got.row, got.first_col, got.stop_col, got.empty, got.last));
			end else begin
				want = spans_due.pop_front();
				if (got !== want)
					report_mismatch($sformatf({"got row=%0d cols=[%0d,%0d) empty=%b last=%b, ",
						"want row=%0d cols=[%0d,%0d) empty=%b last=%b"},
						got.row, got.first_col, got.stop_col, got.empty, got.last,
						want.row, want.first_col, want.stop_col, want.empty, want.last));
			end
		end
	end

	// main sequence
	initial begin : stimulus
		int p, k;
		logic [12:0] w_val;
		logic [12:0] h_val;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = dsg_pkg::CFG_MASK_WIDTH;
		cfg_data   = '0;
		mask_w     = dsg_pkg::DIM_RESET;
		mask_h     = dsg_pkg::DIM_RESET;
		mismatches = 0;
		burst_left = 0;
		no_gaps    = 1'b0;
		hold_req   = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed discs at the reset mask size
		for (k = 0; k < N_DIRECTED; k++)
			send_disc(directed_discs[k].cx, directed_discs[k].cy,
				directed_discs[k].rad, directed_discs[k].typed);

		// random discs over a series of mask settings
		for (p = 0; p < N_PHASES; p++) begin
			wait_drained();
			if (mask_phases[p].rand_dims) begin
				w_val = 13'($urandom_range(1, 4096));
				h_val = 13'($urandom_range(1, 4096));
			end else begin
				w_val = mask_phases[p].w;
				h_val = mask_phases[p].h;
			end
			write_mask_reg(dsg_pkg::CFG_MASK_WIDTH, w_val);
			write_mask_reg(dsg_pkg::CFG_MASK_HEIGHT, h_val);
			if (mask_phases[p].hold) begin
				hold_req = 1'b1;
				no_gaps  = 1'b1;
			end
			for (k = 0; k < mask_phases[p].n_discs; k++) begin
				if (k == 12)
					no_gaps = 1'b0;
				// one pause mid-phase until all spans are in
				if (p == N_PHASES - 1 && k == 30)
					wait_drained();
				send_random_disc();
			end
		end

		wait_drained();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== disc_span_generator.f =====
sv/dsg_pkg.sv
sv/dsg_front.sv
sv/dsg_fifo.sv
sv/dsg_back.sv
sv/disc_span_generator.sv
sv/dsg_checker.sv
bench/disc_span_generator_test.sv
